// ===== sv/c8_pkg.sv =====
// Package for the CHIP-8 core: types, codes, font table.
`default_nettype none
package c8_pkg;

   localparam int MEMORY_BYTES  = 4096;
   localparam int SCREEN_WIDTH  = 64;
   localparam int SCREEN_HEIGHT = 32;
   localparam int FONT_BYTES    = 80;

   localparam logic [11:0] PC_RESET  = 12'h200;
   localparam logic [11:0] FONT_BASE = 12'h050;

   typedef enum logic [1:0] {
      REQ_LOAD = 2'd0,
      REQ_EXEC = 2'd1,
      REQ_TICK = 2'd2,
      REQ_ROW  = 2'd3
   } req_kind_type;

   localparam logic [15:0] OP_CLS  = 16'h00E0;
   localparam logic [7:0]  OP_SKP  = 8'h9E;
   localparam logic [7:0]  OP_SKNP = 8'hA1;
   localparam logic [7:0]  OP_GDT  = 8'h07;
   localparam logic [7:0]  OP_SDT  = 8'h15;
   localparam logic [7:0]  OP_SST  = 8'h18;
   localparam logic [3:0]  GRP_SYS = 4'h0;
   localparam logic [3:0]  GRP_JP  = 4'h1;
   localparam logic [3:0]  GRP_LDI = 4'hA;
   localparam logic [3:0]  GRP_LD  = 4'h6;
   localparam logic [3:0]  GRP_ADD = 4'h7;
   localparam logic [3:0]  GRP_DRW = 4'hD;
   localparam logic [3:0]  GRP_KEY = 4'hE;
   localparam logic [3:0]  GRP_MISC = 4'hF;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [11:0] load_address;
      logic [7:0]  load_byte;
      logic [15:0] keys_pressed;
      logic [4:0]  display_row;
   } req_type_type;

   typedef struct packed {
      logic [11:0] program_counter_now;
      logic [15:0] fetched_opcode;
      logic        unknown_opcode;
      logic [7:0]  collision_flag;
      logic        beep;
      logic        sound_on;
      logic [63:0] row_pixels;
   } rsp_type_type;

   typedef enum logic [3:0] {
      ST_INIT,
      ST_IDLE,
      ST_FETCH_HI,
      ST_FETCH_LO,
      ST_DECODE,
      ST_DRAW_RD,
      ST_DRAW_ROW,
      ST_DRAW_WR,
      ST_CLS,
      ST_ROW_RD,
      ST_DONE
   } state_type;

   function automatic logic [7:0] font_byte(input logic [6:0] idx);
      logic [7:0] b;
      case (idx)
         7'd0: b = 8'hF0;  7'd1: b = 8'h90;  7'd2: b = 8'h90;  7'd3: b = 8'h90;
         7'd4: b = 8'hF0;  7'd5: b = 8'h20;  7'd6: b = 8'h60;  7'd7: b = 8'h20;
         7'd8: b = 8'h20;  7'd9: b = 8'h70;  7'd10: b = 8'hF0; 7'd11: b = 8'h10;
         7'd12: b = 8'hF0; 7'd13: b = 8'h80; 7'd14: b = 8'hF0; 7'd15: b = 8'hF0;
         7'd16: b = 8'h10; 7'd17: b = 8'hF0; 7'd18: b = 8'h10; 7'd19: b = 8'hF0;
         7'd20: b = 8'h90; 7'd21: b = 8'h90; 7'd22: b = 8'hF0; 7'd23: b = 8'h10;
         7'd24: b = 8'h10; 7'd25: b = 8'hF0; 7'd26: b = 8'h80; 7'd27: b = 8'hF0;
         7'd28: b = 8'h10; 7'd29: b = 8'hF0; 7'd30: b = 8'hF0; 7'd31: b = 8'h80;
         7'd32: b = 8'hF0; 7'd33: b = 8'h90; 7'd34: b = 8'hF0; 7'd35: b = 8'hF0;
         7'd36: b = 8'h10; 7'd37: b = 8'h20; 7'd38: b = 8'h40; 7'd39: b = 8'h40;
         7'd40: b = 8'hF0; 7'd41: b = 8'h90; 7'd42: b = 8'hF0; 7'd43: b = 8'h90;
         7'd44: b = 8'hF0; 7'd45: b = 8'hF0; 7'd46: b = 8'h90; 7'd47: b = 8'hF0;
         7'd48: b = 8'h10; 7'd49: b = 8'hF0; 7'd50: b = 8'hF0; 7'd51: b = 8'h90;
         7'd52: b = 8'hF0; 7'd53: b = 8'h90; 7'd54: b = 8'h90; 7'd55: b = 8'hE0;
         7'd56: b = 8'h90; 7'd57: b = 8'hE0; 7'd58: b = 8'h90; 7'd59: b = 8'hE0;
         7'd60: b = 8'hF0; 7'd61: b = 8'h80; 7'd62: b = 8'h80; 7'd63: b = 8'h80;
         7'd64: b = 8'hF0; 7'd65: b = 8'hE0; 7'd66: b = 8'h90; 7'd67: b = 8'h90;
         7'd68: b = 8'h90; 7'd69: b = 8'hE0; 7'd70: b = 8'hF0; 7'd71: b = 8'h80;
         7'd72: b = 8'hF0; 7'd73: b = 8'h80; 7'd74: b = 8'hF0; 7'd75: b = 8'hF0;
         7'd76: b = 8'h80; 7'd77: b = 8'hF0; 7'd78: b = 8'h80; 7'd79: b = 8'h80;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

endpackage
`default_nettype wire

// ===== sv/chip8_cpu_core.sv =====
// Top level of the CHIP-8 core: sequencer around program memory and frame buffer.
//
//  channel | dir | handshake           | payload
//  req     | in  | req_valid/req_ready | c8_pkg::req_type_type
//  rsp     | out | rsp_valid/rsp_ready | c8_pkg::rsp_type_type
//
// One item at a time. An execute fetches two bytes and decodes; DXYN then reads,
// merges and writes each drawn row, 00E0 clears every row. Each memory has one port.
// After reset a clearing pass writes zeros and the font into all MEMORY_BYTES bytes of
// program memory and SCREEN_HEIGHT rows into the frame buffer; no item is taken.
// A result stays in the output register until taken; req_ready is low meanwhile.
`default_nettype none
module chip8_cpu_core #(
   parameter int MEMORY_BYTES  = c8_pkg::MEMORY_BYTES,
   parameter int SCREEN_HEIGHT = c8_pkg::SCREEN_HEIGHT
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire c8_pkg::req_type_type req_data,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output c8_pkg::rsp_type_type      rsp_data
);

   localparam int AW = $clog2(MEMORY_BYTES);
   localparam int RW = $clog2(SCREEN_HEIGHT);

   c8_pkg::state_type state_ff, state_in;

   c8_pkg::req_type_type req_ff, req_in;
   logic [AW-1:0] pc_ff, pc_in, i_ff, i_in;
   logic [7:0]    v_ff [16];
   logic [7:0]    v_in [16];
   logic [7:0]    dt_ff, dt_in, st_ff, st_in;
   logic [15:0]   op_ff, op_in;
   logic [AW-1:0] cnt_ff, cnt_in;
   logic [7:0]    sprite_ff, sprite_in;
   logic [63:0]   line_ff, line_in;
   logic [5:0]    xpos_ff, xpos_in;
   logic [4:0]    ypos_ff, ypos_in;
   logic          rsp_valid_ff, rsp_valid_in;
   c8_pkg::rsp_type_type rsp_ff, rsp_in;

   // memory ports
   logic          pm_we;
   logic [AW-1:0] pm_addr;
   logic [7:0]    pm_wdata, pm_rdata;
   logic          fb_we;
   logic [RW-1:0] fb_addr;
   logic [63:0]   fb_wdata, fb_rdata;

   c8_ram #(.WIDTH(8), .DEPTH(MEMORY_BYTES)) u_pmem (
      .clock(clock), .wr_en(pm_we), .addr(pm_addr), .wr_data(pm_wdata), .rd_data(pm_rdata)
   );
   c8_ram #(.WIDTH(64), .DEPTH(SCREEN_HEIGHT)) u_fbuf (
      .clock(clock), .wr_en(fb_we), .addr(fb_addr), .wr_data(fb_wdata), .rd_data(fb_rdata)
   );

   logic [3:0]  vx_sel, vy_sel, nrows;
   logic [7:0]  vx_val, vy_val, low;
   logic [5:0]  xpos;
   logic [4:0]  ypos;
   logic [5:0]  row_abs;
   logic [71:0] spread;
   logic        key_down;
   logic [6:0]  font_idx;
   logic [AW-1:0] font_off;

   always_comb begin
      vx_sel   = op_ff[11:8];
      vy_sel   = op_ff[7:4];
      nrows    = op_ff[3:0];
      low      = op_ff[7:0];
      vx_val   = v_ff[vx_sel];
      vy_val   = v_ff[vy_sel];
      xpos     = vx_val[5:0];
      ypos     = vy_val[4:0];
      row_abs  = {1'b0, ypos_ff} + {2'b00, cnt_ff[3:0]};
      // sprite placed at the latched column, pixels past column 63 fall off the low end
      spread   = {sprite_ff, 64'd0} >> xpos_ff;
      key_down = req_ff.keys_pressed[vx_val[3:0]];
      font_off = cnt_ff - c8_pkg::FONT_BASE;
      font_idx = font_off[6:0];
   end

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      pc_in        = pc_ff;
      i_in         = i_ff;
      v_in         = v_ff;
      dt_in        = dt_ff;
      st_in        = st_ff;
      op_in        = op_ff;
      cnt_in       = cnt_ff;
      sprite_in    = sprite_ff;
      line_in      = line_ff;
      xpos_in      = xpos_ff;
      ypos_in      = ypos_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      pm_we        = 1'b0;
      pm_addr      = pc_ff;
      pm_wdata     = 8'd0;
      fb_we        = 1'b0;
      fb_addr      = cnt_ff[RW-1:0];
      fb_wdata     = 64'd0;
      req_ready    = 1'b0;

      case (state_ff)
         c8_pkg::ST_INIT: begin
            pm_we   = 1'b1;
            pm_addr = cnt_ff;
            pm_wdata = (cnt_ff >= c8_pkg::FONT_BASE &&
                        font_off < AW'(c8_pkg::FONT_BYTES)) ?
                       c8_pkg::font_byte(font_idx) : 8'd0;
            fb_we   = (cnt_ff < AW'(SCREEN_HEIGHT));
            cnt_in  = cnt_ff + 1'b1;
            if (cnt_ff == AW'(MEMORY_BYTES - 1)) begin
               state_in = c8_pkg::ST_IDLE;
            end
         end
         c8_pkg::ST_IDLE: begin
            req_ready = !rsp_valid_ff;
            if (req_valid && !rsp_valid_ff) begin
               req_in = req_data;
               rsp_in = '0;
               case (c8_pkg::req_kind_type'(req_data.req_type))
                  c8_pkg::REQ_LOAD: begin
                     pm_we    = 1'b1;
                     pm_addr  = req_data.load_address;
                     pm_wdata = req_data.load_byte;
                     state_in = c8_pkg::ST_DONE;
                  end
                  c8_pkg::REQ_EXEC: begin
                     pm_addr  = pc_ff;
                     state_in = c8_pkg::ST_FETCH_HI;
                  end
                  c8_pkg::REQ_TICK: begin
                     if (dt_ff != 8'd0) dt_in = dt_ff - 8'd1;
                     if (st_ff != 8'd0) st_in = st_ff - 8'd1;
                     rsp_in.beep = (st_ff == 8'd1);
                     state_in = c8_pkg::ST_DONE;
                  end
                  c8_pkg::REQ_ROW: begin
                     fb_addr  = req_data.display_row[RW-1:0];
                     state_in = c8_pkg::ST_ROW_RD;
                  end
                  default: state_in = c8_pkg::ST_DONE;
               endcase
            end
         end
         c8_pkg::ST_FETCH_HI: begin
            pm_addr     = pc_ff + 1'b1;
            op_in[15:8] = pm_rdata;
            state_in    = c8_pkg::ST_FETCH_LO;
         end
         c8_pkg::ST_FETCH_LO: begin
            op_in[7:0] = pm_rdata;
            state_in   = c8_pkg::ST_DECODE;
         end
         c8_pkg::ST_DECODE: begin
            rsp_in.fetched_opcode = op_ff;
            pc_in    = pc_ff + AW'(2);
            state_in = c8_pkg::ST_DONE;
            case (op_ff[15:12])
               c8_pkg::GRP_SYS: begin
                  if (op_ff == c8_pkg::OP_CLS) begin
                     cnt_in   = '0;
                     state_in = c8_pkg::ST_CLS;
                  end else begin
                     rsp_in.unknown_opcode = 1'b1;
                  end
               end
               c8_pkg::GRP_JP:  pc_in = op_ff[11:0];
               c8_pkg::GRP_LDI: i_in  = op_ff[11:0];
               c8_pkg::GRP_LD:  v_in[vx_sel] = low;
               c8_pkg::GRP_ADD: v_in[vx_sel] = vx_val + low;
               c8_pkg::GRP_DRW: begin
                  // position taken before VF is cleared, VX or VY may be VF
                  xpos_in  = xpos;
                  ypos_in  = ypos;
                  v_in[15] = 8'd0;
                  cnt_in   = '0;
                  if (nrows != 4'd0) begin
                     state_in = c8_pkg::ST_DRAW_RD;
                  end
               end
               c8_pkg::GRP_KEY: begin
                  if (low == c8_pkg::OP_SKP) begin
                     if (key_down) pc_in = pc_ff + AW'(4);
                  end else if (low == c8_pkg::OP_SKNP) begin
                     if (!key_down) pc_in = pc_ff + AW'(4);
                  end else begin
                     rsp_in.unknown_opcode = 1'b1;
                  end
               end
               c8_pkg::GRP_MISC: begin
                  if (low == c8_pkg::OP_GDT)      v_in[vx_sel] = dt_ff;
                  else if (low == c8_pkg::OP_SDT) dt_in = vx_val;
                  else if (low == c8_pkg::OP_SST) st_in = vx_val;
                  else rsp_in.unknown_opcode = 1'b1;
               end
               default: rsp_in.unknown_opcode = 1'b1;
            endcase
         end
         c8_pkg::ST_DRAW_RD: begin
            // sprite byte and target row requested together
            pm_addr  = i_ff + cnt_ff;
            fb_addr  = row_abs[RW-1:0];
            state_in = c8_pkg::ST_DRAW_ROW;
         end
         c8_pkg::ST_DRAW_ROW: begin
            sprite_in = pm_rdata;
            line_in   = fb_rdata;
            state_in  = c8_pkg::ST_DRAW_WR;
         end
         c8_pkg::ST_DRAW_WR: begin
            fb_we    = 1'b1;
            fb_addr  = row_abs[RW-1:0];
            fb_wdata = line_ff ^ spread[71:8];
            if ((line_ff & spread[71:8]) != 64'd0) v_in[15] = 8'd1;
            cnt_in   = cnt_ff + 1'b1;
            if (cnt_ff[3:0] + 4'd1 == nrows || row_abs == 6'(SCREEN_HEIGHT - 1)) begin
               state_in = c8_pkg::ST_DONE;
            end else begin
               state_in = c8_pkg::ST_DRAW_RD;
            end
         end
         c8_pkg::ST_CLS: begin
            fb_we   = 1'b1;
            cnt_in  = cnt_ff + 1'b1;
            if (cnt_ff == AW'(SCREEN_HEIGHT - 1)) state_in = c8_pkg::ST_DONE;
         end
         c8_pkg::ST_ROW_RD: begin
            rsp_in.row_pixels = fb_rdata;
            state_in = c8_pkg::ST_DONE;
         end
         c8_pkg::ST_DONE: begin
            rsp_in.program_counter_now = pc_ff;
            rsp_in.collision_flag      = v_ff[15];
            rsp_in.sound_on            = (st_ff != 8'd0);
            rsp_valid_in = 1'b1;
            state_in     = c8_pkg::ST_IDLE;
         end
         default: state_in = c8_pkg::ST_IDLE;
      endcase

      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= c8_pkg::ST_INIT;
         cnt_ff       <= '0;
         pc_ff        <= c8_pkg::PC_RESET;
         i_ff         <= '0;
         dt_ff        <= '0;
         st_ff        <= '0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < 16; k++) v_ff[k] <= '0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         pc_ff        <= pc_in;
         i_ff         <= i_in;
         dt_ff        <= dt_in;
         st_ff        <= st_in;
         rsp_valid_ff <= rsp_valid_in;
         v_ff         <= v_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff    <= req_in;
      op_ff     <= op_in;
      sprite_ff <= sprite_in;
      line_ff   <= line_in;
      xpos_ff   <= xpos_in;
      ypos_ff   <= ypos_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
`default_nettype wire

// ===== sv/c8_ram.sv =====
// Generic single-port RAM with registered read.
`default_nettype none
module c8_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end

endmodule
`default_nettype wire

// ===== sv/c8_checker.sv =====
// Port-level checker for the CHIP-8 core, bound to the top level.
`default_nettype none
module c8_checker (
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 req_valid,
   input wire logic                 req_ready,
   input wire c8_pkg::req_type_type req_data,
   input wire logic                 rsp_valid,
   input wire logic                 rsp_ready,
   input wire c8_pkg::rsp_type_type rsp_data
);

   // a taken item never coincides with a pending result
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !rsp_valid) else $error("request taken while result pending");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result dropped or changed under stall");

   // a response with row pixels carries no opcode, unknown-opcode flag or beep
   a_row_only: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.row_pixels != 64'd0 |->
      rsp_data.fetched_opcode == 16'd0 && !rsp_data.unknown_opcode && !rsp_data.beep)
      else $error("row pixels mixed with other results");

   a_beep_silent: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.beep |-> !rsp_data.sound_on)
      else $error("beep while sound still on");

   a_no_rsp_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid) else $error("result out of reset");

endmodule

bind chip8_cpu_core c8_checker u_c8_checker (
   .clock(clock), .reset(reset),
   .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
);
`default_nettype wire
